FILE: sv/pes_video_picture_type_scan_macros.svh
// Assertion macros for the video packet picture type scan
`ifndef PES_VIDEO_PICTURE_TYPE_SCAN_MACROS_SVH
`define PES_VIDEO_PICTURE_TYPE_SCAN_MACROS_SVH

// check a condition at every clock edge out of reset
`define PVPTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// check that a condition in one cycle implies another in the next
`define PVPTS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/pvpts_pkg.sv
// Shared types and constants for the video packet picture type scan
`timescale 1ns / 1ps
`default_nettype none
package pvpts_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [16:0] pos_t;
    typedef logic [15:0] len_t;
    typedef logic [8:0]  pstart_t;
    typedef logic [2:0]  ptype_t;
    typedef logic [1:0]  count_t;

    localparam pos_t    POS_LEN_HI   = 17'd4;
    localparam pos_t    POS_LEN_LO   = 17'd5;
    localparam pos_t    POS_HDR_CNT  = 17'd8;
    localparam pstart_t HDR_MIN      = 9'd9;
    localparam pos_t    LENGTH_EXTRA = 17'd6;
    localparam logic [31:0] START_WORD = 32'h0000_0100;
    localparam count_t  TYPE_DELAY   = 2'd2;

    typedef struct packed {
        byte_t byte_value;
        logic  packet_start;
        logic  last_byte;
    } beat_t;

    typedef struct packed {
        logic   complete;
        pos_t   packet_length;
        logic   has_picture;
        ptype_t picture_type;
    } res_t;

endpackage
`default_nettype wire

FILE: sv/pvpts_in_reg.sv
// Input register stage for incoming byte beats
`timescale 1ns / 1ps
`default_nettype none
module pvpts_in_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pvpts_pkg::beat_t s_beat,
    input  wire logic            drain,
    output logic                 vld,
    output pvpts_pkg::beat_t     beat
);
    import pvpts_pkg::*;

    logic  vld_reg, vld_next;
    beat_t beat_reg, beat_next;

    assign s_ready = !vld_reg || drain;

    always_comb begin
        vld_next  = vld_reg;
        beat_next = beat_reg;
        if (drain) begin
            vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            vld_next  = 1'b1;
            beat_next = s_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        beat_reg <= beat_next;
    end

    assign vld  = vld_reg;
    assign beat = beat_reg;
endmodule
`default_nettype wire

FILE: sv/pvpts_scan.sv
// Packet scan state and per-byte update logic
`timescale 1ns / 1ps
`default_nettype none
module pvpts_scan (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire pvpts_pkg::beat_t beat,
    output logic                  res_valid,
    output pvpts_pkg::res_t       res
);
    import pvpts_pkg::*;

    logic    active_reg, active_next;
    pos_t    pos_reg, pos_next;
    len_t    len_reg, len_next;
    pstart_t ps_reg, ps_next;
    logic [23:0] recent_reg, recent_next;
    count_t  cd_reg, cd_next;
    logic    found_reg, found_next;
    ptype_t  type_reg, type_next;

    logic        clr, active_eff, done, hit;
    pos_t        p, total;
    len_t        len_cur;
    pstart_t     ps_cur;
    logic [23:0] recent_cur;
    count_t      cd_cur;
    logic        found_cur;
    ptype_t      type_cur;
    logic [31:0] word;
    byte_t       b;

    always_comb begin
        b          = beat.byte_value;
        clr        = beat.packet_start;
        active_eff = clr || active_reg;
        p          = clr ? '0 : pos_reg;
        len_cur    = clr ? '0 : len_reg;
        ps_cur     = clr ? '0 : ps_reg;
        recent_cur = clr ? '0 : recent_reg;
        cd_cur     = clr ? '0 : cd_reg;
        found_cur  = clr ? 1'b0 : found_reg;
        type_cur   = clr ? '0 : type_reg;

        len_next = len_cur;
        if (p == POS_LEN_HI) begin
            len_next = {b, 8'h00};
        end else if (p == POS_LEN_LO) begin
            len_next = {len_cur[15:8], b};
        end
        ps_next = ps_cur;
        if (p == POS_HDR_CNT) begin
            ps_next = HDR_MIN + {1'b0, b};
        end
        total = {1'b0, len_next} + LENGTH_EXTRA;
        word  = {recent_cur, b};

        hit = !found_cur && (p > POS_HDR_CNT)
            && (p >= ({8'b0, ps_next} + 17'd3))
            && (({1'b0, p} + 18'd2) < {1'b0, total})
            && (word == START_WORD);

        cd_next    = cd_cur;
        found_next = found_cur;
        type_next  = type_cur;
        if (cd_cur != '0) begin
            if (cd_cur == 2'd1) begin
                found_next = 1'b1;
                type_next  = b[5:3];
            end
            cd_next = cd_cur - 2'd1;
        end else if (hit) begin
            cd_next = TYPE_DELAY;
        end

        done = (p >= POS_LEN_LO) && (({1'b0, p} + 18'd1) == {1'b0, total});

        res_valid         = active_eff && (done || beat.last_byte);
        res.complete      = done;
        res.packet_length = done ? total : '0;
        res.has_picture   = done && found_next;
        res.picture_type  = (done && found_next) ? type_next : '0;

        active_next = active_eff && !(done || beat.last_byte);
        pos_next    = p + 17'd1;
        recent_next = word[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            len_reg    <= '0;
            ps_reg     <= '0;
            recent_reg <= '0;
            cd_reg     <= '0;
            found_reg  <= 1'b0;
            type_reg   <= '0;
        end else if (step && active_eff) begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            ps_reg     <= ps_next;
            recent_reg <= recent_next;
            cd_reg     <= cd_next;
            found_reg  <= found_next;
            type_reg   <= type_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/pvpts_out_reg.sv
// Result register stage
`timescale 1ns / 1ps
`default_nettype none
module pvpts_out_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire pvpts_pkg::res_t res_in,
    output logic                 free,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pvpts_pkg::res_t      res_out
);
    import pvpts_pkg::*;

    logic vld_reg, vld_next;
    res_t res_reg, res_next;

    assign free = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg && !m_ready;
        res_next = res_reg;
        if (load) begin
            vld_next = 1'b1;
            res_next = res_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        res_reg <= res_next;
    end

    assign m_valid = vld_reg;
    assign res_out = res_reg;
endmodule
`default_nettype wire

FILE: sv/pes_video_picture_type_scan.sv
// Path: beat -> input register -> scan update -> result register -> m_valid.
// Throughput: one byte per cycle; the input register, scan update and result
// register form a single pass with no iteration. A held result stalls the input.
// Reset: synchronous active-low aresetn clears both stage valids and all scan state.
// Top level of the video packet picture type scan
`timescale 1ns / 1ps
`default_nettype none
module pes_video_picture_type_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pvpts_pkg::byte_t     s_byte_value,
    input  wire logic                 s_packet_start,
    input  wire logic                 s_last_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_complete,
    output pvpts_pkg::pos_t           m_packet_length,
    output logic                      m_has_picture,
    output pvpts_pkg::ptype_t         m_picture_type
);
    import pvpts_pkg::*;

    beat_t s_beat, beat;
    logic  in_vld, free, step, res_valid;
    res_t  res, res_out;

    assign s_beat = '{byte_value: s_byte_value, packet_start: s_packet_start,
                      last_byte: s_last_byte};
    assign step   = in_vld && free;

    pvpts_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .drain   (step),
        .vld     (in_vld),
        .beat    (beat)
    );

    pvpts_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    pvpts_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step && res_valid),
        .res_in  (res),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_out (res_out)
    );

    assign m_complete      = res_out.complete;
    assign m_packet_length = res_out.packet_length;
    assign m_has_picture   = res_out.has_picture;
    assign m_picture_type  = res_out.picture_type;
endmodule
`default_nettype wire

FILE: sv/pvpts_checker.sv
// Port-level checks for the video packet picture type scan, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "pes_video_picture_type_scan_macros.svh"
module pvpts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_complete,
    input wire logic [16:0] m_packet_length,
    input wire logic        m_has_picture,
    input wire logic [2:0]  m_picture_type
);
    `PVPTS_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_packet_length) && $stable(m_picture_type), "result beat changed while stalled")
    `PVPTS_ASSERT_ALWAYS(a_incomplete, !m_valid || m_complete || (m_packet_length == 17'd0 && !m_has_picture && m_picture_type == 3'd0), "incomplete result carries data")
    `PVPTS_ASSERT_ALWAYS(a_min_len, !m_valid || !m_complete || m_packet_length >= 17'd6, "complete packet shorter than header")
    `PVPTS_ASSERT_ALWAYS(a_no_type, !m_valid || m_has_picture || m_picture_type == 3'd0, "picture type without picture")
endmodule

bind pes_video_picture_type_scan pvpts_checker u_pvpts_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_complete      (m_complete),
    .m_packet_length (m_packet_length),
    .m_has_picture   (m_has_picture),
    .m_picture_type  (m_picture_type)
);
`default_nettype wire

FILE: bench/tb_pes_video_picture_type_scan.sv
// Testbench for the video packet picture type scan: directed rows, random packets, scoreboard
`timescale 1ns / 1ps
module tb_pes_video_picture_type_scan;
    import pvpts_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned PHASE_BEATS   = 300;
    localparam int unsigned MIN_RESULTS   = 40;
    localparam int unsigned BUILT_CAP     = 600;
    localparam int unsigned MAX_PKT_BEATS = 64;
    localparam int unsigned N_ROWS        = 25;
    localparam res_t        RES_INCOMPLETE = '0;

    typedef struct packed {
        byte_t b;
        logic  st;
        logic  lb;
        logic  typed;
        logic  want;
        res_t  res;
    } row_t;

    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, RES_INCOMPLETE},
        '{8'hA5, 1'b1, 1'b0, 1'b1, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, RES_INCOMPLETE},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'hE0, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h38, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 17'd16, 1'b1, 3'd7}},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'hBD, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_INCOMPLETE},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 17'd6, 1'b0, 3'd0}}
    };

    logic   aclk           = 1'b0;
    logic   aresetn        = 1'b0;
    logic   s_valid        = 1'b0;
    logic   s_ready;
    byte_t  s_byte_value   = '0;
    logic   s_packet_start = 1'b0;
    logic   s_last_byte    = 1'b0;
    logic   m_valid;
    logic   m_ready        = 1'b0;
    logic   m_complete;
    pos_t   m_packet_length;
    logic   m_has_picture;
    ptype_t m_picture_type;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned stall_cycles  = 0;
    int unsigned packet_beats  = 0;
    int unsigned results_checked  = 0;
    int unsigned complete_results = 0;
    int unsigned picture_results  = 0;
    int unsigned mismatches       = 0;

    res_t pending_results[$];

    logic        scan_on     = 1'b0;
    int unsigned scan_offset = 0;
    len_t        scan_len    = '0;
    pstart_t     scan_hdr_end = '0;
    logic [31:0] scan_window = '0;
    count_t      scan_countdown = '0;
    logic        scan_found  = 1'b0;
    ptype_t      scan_kind   = '0;

    pes_video_picture_type_scan u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_packet_start  (s_packet_start),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_complete      (m_complete),
        .m_packet_length (m_packet_length),
        .m_has_picture   (m_has_picture),
        .m_picture_type  (m_picture_type)
    );

    always #5 aclk = ~aclk;

    task automatic picture_scan_step(input byte_t b, input logic st, input logic lb,
                                     output logic produced, output res_t r);
        int unsigned p;
        int unsigned total;
        produced = 1'b0;
        r = RES_INCOMPLETE;
        if (st) begin
            scan_on        = 1'b1;
            scan_offset    = 0;
            scan_len       = '0;
            scan_hdr_end   = '0;
            scan_window    = '0;
            scan_countdown = '0;
            scan_found     = 1'b0;
            scan_kind      = '0;
        end
        if (!scan_on) return;
        p = scan_offset;
        scan_window = {scan_window[23:0], b};
        if (p == POS_LEN_HI) scan_len = {b, 8'h00};
        if (p == POS_LEN_LO) scan_len = {scan_len[15:8], b};
        if (p == POS_HDR_CNT) scan_hdr_end = HDR_MIN + pstart_t'(b);
        total = int'(scan_len) + int'(LENGTH_EXTRA);
        if (scan_countdown != '0) begin
            if (scan_countdown == 2'd1) begin
                scan_found = 1'b1;
                scan_kind  = b[5:3];
            end
            scan_countdown = scan_countdown - 2'd1;
        end else if (!scan_found && p > POS_HDR_CNT && p >= int'(scan_hdr_end) + 3 &&
                     p + 2 < total && scan_window == START_WORD) begin
            scan_countdown = TYPE_DELAY;
        end
        if (p >= POS_LEN_LO && p + 1 == total) begin
            produced        = 1'b1;
            r.complete      = 1'b1;
            r.packet_length = pos_t'(total);
            r.has_picture   = scan_found;
            r.picture_type  = scan_found ? scan_kind : ptype_t'(0);
            scan_on = 1'b0;
            return;
        end
        if (lb) begin
            produced = 1'b1;
            scan_on  = 1'b0;
            return;
        end
        scan_offset = p + 1;
    endtask

    task automatic send_beat(input byte_t b, input logic st, input logic lb,
                             input logic typed = 1'b0, input logic want = 1'b0,
                             input res_t fixed = '0);
        logic produced;
        res_t r;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_byte_value   <= b;
        s_packet_start <= st;
        s_last_byte    <= lb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        picture_scan_step(b, st, lb, produced, r);
        if (typed) begin
            produced = want;
            r = fixed;
        end
        if (produced) pending_results.push_back(r);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_beat(byte_t'($urandom), 1'b0, $urandom_range(0, 1) == 1);
    endtask

    task automatic send_random_packet(input bit max_size);
        byte_t       pkt[$];
        int unsigned len;
        int unsigned total;
        int unsigned built;
        int unsigned count;
        int unsigned at;
        int unsigned sel;
        logic        lb;
        sel = $urandom_range(0, 99);
        if (max_size) len = 16'hFFFF;
        else if (sel < 65) len = $urandom_range(0, 24);
        else if (sel < 85) len = $urandom_range(25, 120);
        else if (sel < 95) len = $urandom_range(121, 400);
        else len = $urandom_range(0, 65535);
        total = len + LENGTH_EXTRA;
        built = (total <= BUILT_CAP) ? total : BUILT_CAP;
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        pkt.push_back(($urandom_range(0, 3) == 0) ? byte_t'($urandom) : 8'hE0);
        pkt.push_back(byte_t'(len >> 8));
        pkt.push_back(byte_t'(len));
        pkt.push_back(byte_t'($urandom));
        pkt.push_back(byte_t'($urandom));
        pkt.push_back(($urandom_range(0, 99) < 80) ? byte_t'($urandom_range(0, 4))
                                                   : byte_t'($urandom));
        while (pkt.size() < built)
            pkt.push_back(($urandom_range(0, 99) < 40) ? 8'h00 : byte_t'($urandom));
        if (built > 13) begin
            repeat ($urandom_range(0, 3)) begin
                at = $urandom_range(9, built - 4);
                pkt[at]     = 8'h00;
                pkt[at + 1] = 8'h00;
                pkt[at + 2] = 8'h01;
                pkt[at + 3] = 8'h00;
                if (at + 5 < built) pkt[at + 5] = byte_t'($urandom);
            end
        end
        sel = $urandom_range(0, 99);
        if (max_size) begin
            count = MAX_PKT_BEATS;
            lb = 1'b1;
        end else if (built < total) begin
            count = $urandom_range(1, built);
            lb = 1'b1;
        end else if (sel < 12) begin
            count = $urandom_range(1, total - 1);
            lb = 1'b1;
        end else if (sel < 20) begin
            count = $urandom_range(1, total - 1);
            lb = 1'b0;
        end else begin
            count = total;
            lb = ($urandom_range(0, 3) == 0);
        end
        for (int i = 0; i < count; i++)
            send_beat(pkt[i], i == 0, (i == count - 1) && lb);
        packet_beats += count;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %b/%0d/%b/%0d",
                         $time, m_complete, m_packet_length, m_has_picture, m_picture_type);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("complete", want.complete, m_complete);
                check_field("packet_length", want.packet_length, m_packet_length);
                check_field("has_picture", want.has_picture, m_has_picture);
                check_field("picture_type", want.picture_type, m_picture_type);
                results_checked++;
                if (want.complete) complete_results++;
                if (want.has_picture) picture_results++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        src_idle_pct  = 28;
        sink_idle_pct = 62;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_ROWS; i++)
            send_beat(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].lb,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want, DIRECTED_ROWS[i].res);
        hold_until_drained();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 28;
                    sink_idle_pct = 62;
                end
                1: begin
                    src_idle_pct  = 62;
                    sink_idle_pct = 28;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    send_random_packet(1'b1);
                end
            endcase
            while (packet_beats < (phase + 1) * PHASE_BEATS ||
                   (phase == 2 && results_checked < MIN_RESULTS)) begin
                if ($urandom_range(0, 99) < 20) send_noise();
                send_random_packet(1'b0);
            end
            hold_until_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Scanned %0d packet bytes plus directed rows, one with the largest length field.",
                 packet_beats);
        $display("Checked %0d results: %0d complete, %0d with a picture, %0d mismatches.",
                 results_checked, complete_results, picture_results, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
